### design/block_average_density_histogram_top_macros.svh
// Assertion macros for the block-average density histogram.
// Used by badh_acc and badh_hist; expects clk and rst in scope.
`ifndef BLOCK_AVERAGE_DENSITY_HISTOGRAM_TOP_MACROS_SVH
`define BLOCK_AVERAGE_DENSITY_HISTOGRAM_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define BADH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("badh assertion failed");
// next-cycle implication
`define BADH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("badh assertion failed");
`else
`define BADH_ASSERT_IMP(lbl, ante, cons)
`define BADH_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### design/badh_pkg.sv
// Shared constants, types and FSM states for the block-average density histogram.
// No dependencies.
package badh_pkg;

  localparam int MESH_MAX      = 128;
  localparam int SLAB_DEPTH    = 16384;
  localparam int BINS_MAX      = 64;

  localparam int MESH_LOG2_MAX = $clog2(MESH_MAX);
  localparam int POS_W         = $clog2(MESH_MAX);
  localparam int SLAB_AW       = $clog2(SLAB_DEPTH);
  localparam int BIN_W         = $clog2(BINS_MAX);

  localparam int DEN_W         = 24;
  localparam int SUM_W         = 34;
  localparam int CNT_W         = 22;
  localparam int FRAC_W        = 16;
  localparam int ONE_FIX       = 65536;

  localparam int ML_W          = 3;
  localparam int BL_W          = 2;
  localparam int CFG_BINS_W    = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_MESH_LOG2  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS   = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic               vld;
    logic [DEN_W-1:0]   density;
    logic [SLAB_AW-1:0] idx;
    logic               first;
    logic               last;
    logic [BL_W-1:0]    bl;
  } smp_t;

  typedef struct packed {
    logic             vld;
    logic [SUM_W-1:0] sum;
    logic [BL_W-1:0]  bl;
  } blk_t;

  typedef enum logic [1:0] {
    ST_COUNT,
    ST_DRAIN,
    ST_EMIT,
    ST_FLUSH
  } hist_state_t;

endpackage

### design/block_average_density_histogram_top.sv
// Block-average density histogram, top level.
// Depends on badh_pkg, badh_acc and badh_hist.
//
// Usage:
//   Input channel (in_valid / in_stall / density): one mesh sample per
//   transaction in raster order, x slowest, z fastest.
//   Output channel (out_valid / out_stall / bin_index, block_count, last_bin):
//   after the final sample of a mesh, one transaction per bin in use,
//   last_bin set on the final one; the histogram is then cleared.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//   ready; write only while idle. Writing mesh_log2 or block_log2 restarts
//   the mesh at position 0.
//   Throughput: one sample per cycle, set by the slab memory
//   read-modify-write (one read port, one write port). After the final
//   sample of a mesh, in_stall is high until the last bin transaction is
//   taken: the pipeline drains first, then one bin per cycle follows
//   while out_stall is low.
//   A stalled output transaction holds its payload; the bin reads wait.
//   Reset: positions and histogram cleared, registers to 7, 2 and 64.
//   The slab memory needs no clearing; each block's first sample overwrites.
module block_average_density_histogram_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [badh_pkg::DEN_W-1:0] density,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [badh_pkg::BIN_W-1:0]       bin_index,
  output logic [badh_pkg::CNT_W-1:0]       block_count,
  output logic                             last_bin,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [badh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [badh_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import badh_pkg::*;

  logic [ML_W-1:0]       mesh_log2;
  logic [BL_W-1:0]       block_log2;
  logic [CFG_BINS_W-1:0] num_bins;

  logic [ML_W-1:0]       ml;
  logic [BL_W-1:0]       bl;
  logic [POS_W-1:0]      pmask;
  logic [POS_W-1:0]      bmask;
  logic [CFG_BINS_W-1:0] nb;
  logic [BIN_W-1:0]      nb_m1;

  logic [POS_W-1:0]      pos_x, pos_y, pos_z;
  logic                  z_wrap, y_wrap, x_wrap;
  logic                  accept;
  logic                  cfg_we;
  logic                  run_start;
  logic                  first, last;
  logic [SLAB_AW-1:0]    slab_idx;

  smp_t                  smp;
  blk_t                  blk;
  logic                  acc_busy;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    ml    = (mesh_log2 > ML_W'(MESH_LOG2_MAX)) ? ML_W'(MESH_LOG2_MAX) : mesh_log2;
    bl    = (ML_W'(block_log2) < ml) ? block_log2 : BL_W'(ml);
    pmask = POS_W'(((POS_W+1)'(1) << ml) - (POS_W+1)'(1));
    bmask = POS_W'((4'd1 << bl) - 4'd1);
    if (num_bins == '0) begin
      nb = CFG_BINS_W'(1);
    end else if (num_bins > CFG_BINS_W'(BINS_MAX)) begin
      nb = CFG_BINS_W'(BINS_MAX);
    end else begin
      nb = num_bins;
    end
    nb_m1 = BIN_W'(nb - 1'b1);
  end

  always_comb begin
    z_wrap    = (pos_z == pmask);
    y_wrap    = (pos_y == pmask);
    x_wrap    = (pos_x == pmask);
    first     = ((pos_x | pos_y | pos_z) & bmask) == '0;
    last      = ((pos_x & bmask) == bmask) && ((pos_y & bmask) == bmask) &&
                ((pos_z & bmask) == bmask);
    slab_idx  = (SLAB_AW'(pos_y >> bl) << (ml - ML_W'(bl))) | SLAB_AW'(pos_z >> bl);
    run_start = accept && z_wrap && y_wrap && x_wrap;
  end

  assign smp = '{vld: accept, density: density, idx: slab_idx,
                 first: first, last: last, bl: bl};

  always_ff @(posedge clk) begin
    if (rst) begin
      mesh_log2  <= ML_W'(7);
      block_log2 <= BL_W'(2);
      num_bins   <= CFG_BINS_W'(64);
      pos_x      <= '0;
      pos_y      <= '0;
      pos_z      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MESH_LOG2: begin
          mesh_log2 <= cfg_data[ML_W-1:0];
          pos_x     <= '0;
          pos_y     <= '0;
          pos_z     <= '0;
        end
        CFG_BLOCK_LOG2: begin
          block_log2 <= cfg_data[BL_W-1:0];
          pos_x      <= '0;
          pos_y      <= '0;
          pos_z      <= '0;
        end
        CFG_NUM_BINS: begin
          num_bins <= cfg_data[CFG_BINS_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      pos_z <= z_wrap ? '0 : pos_z + 1'b1;
      if (z_wrap) begin
        pos_y <= y_wrap ? '0 : pos_y + 1'b1;
        if (y_wrap) begin
          pos_x <= x_wrap ? '0 : pos_x + 1'b1;
        end
      end
    end
  end

  badh_acc u_acc (
    .clk  (clk),
    .rst  (rst),
    .smp  (smp),
    .blk  (blk),
    .busy (acc_busy)
  );

  badh_hist u_hist (
    .clk         (clk),
    .rst         (rst),
    .blk         (blk),
    .acc_busy    (acc_busy),
    .run_start   (run_start),
    .nb_m1       (nb_m1),
    .busy        (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bin_index   (bin_index),
    .block_count (block_count),
    .last_bin    (last_bin)
  );

endmodule

### design/badh_acc.sv
// Block partial-sum accumulator: slab memory read-modify-write with forwarding.
// Depends on badh_pkg and block_average_density_histogram_top_macros.svh.
`include "block_average_density_histogram_top_macros.svh"
module badh_acc (
  input  logic           clk,
  input  logic           rst,
  input  badh_pkg::smp_t smp,
  output badh_pkg::blk_t blk,
  output logic           busy
);
  import badh_pkg::*;

  logic [SUM_W-1:0]   slab_mem [SLAB_DEPTH];
  logic [SUM_W-1:0]   slab_q;

  logic               p1_vld;
  logic [SLAB_AW-1:0] p1_idx;
  logic               p1_first;
  logic               p1_last;
  logic [BL_W-1:0]    p1_bl;
  logic [DEN_W-1:0]   p1_den;

  logic               fwd_hit;
  logic [SUM_W-1:0]   fwd_sum;
  logic [SUM_W-1:0]   base;
  logic [SUM_W-1:0]   acc;

  logic               blk_vld;
  logic [SUM_W-1:0]   blk_sum;
  logic [BL_W-1:0]    blk_bl;

  always_ff @(posedge clk) begin
    if (smp.vld) begin
      slab_q <= slab_mem[smp.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (p1_vld) begin
      slab_mem[p1_idx] <= acc;
    end
  end

  always_comb begin
    base = fwd_hit ? fwd_sum : slab_q;
    acc  = p1_first ? SUM_W'($signed(p1_den)) : base + SUM_W'($signed(p1_den));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld  <= 1'b0;
      blk_vld <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      p1_vld  <= smp.vld;
      blk_vld <= p1_vld && p1_last;
      fwd_hit <= smp.vld && p1_vld && (smp.idx == p1_idx);
    end
  end

  always_ff @(posedge clk) begin
    p1_idx   <= smp.idx;
    p1_first <= smp.first;
    p1_last  <= smp.last;
    p1_bl    <= smp.bl;
    p1_den   <= smp.density;
    fwd_sum  <= acc;
    blk_sum  <= acc;
    blk_bl   <= p1_bl;
  end

  assign blk  = '{vld: blk_vld, sum: blk_sum, bl: blk_bl};
  assign busy = p1_vld || blk_vld;

  `BADH_ASSERT_IMP(a_fwd_needs_writer, fwd_hit, p1_vld)
  `BADH_ASSERT_NXT(a_blk_from_last, p1_vld && p1_last, blk_vld)

endmodule

### design/badh_hist.sv
// Block averaging, binning, histogram memory and run emitter.
// Depends on badh_pkg and block_average_density_histogram_top_macros.svh.
`include "block_average_density_histogram_top_macros.svh"
module badh_hist (
  input  logic                          clk,
  input  logic                          rst,
  input  badh_pkg::blk_t                blk,
  input  logic                          acc_busy,
  input  logic                          run_start,
  input  logic [badh_pkg::BIN_W-1:0]    nb_m1,
  output logic                          busy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [badh_pkg::BIN_W-1:0]    bin_index,
  output logic [badh_pkg::CNT_W-1:0]    block_count,
  output logic                          last_bin
);
  import badh_pkg::*;

  localparam int T_W = SUM_W + 5;
  localparam int Q_W = T_W - FRAC_W;

  hist_state_t             state, state_next;

  logic [3:0]              shamt;
  logic signed [SUM_W-1:0] avg;
  logic signed [SUM_W:0]   s_next;
  logic                    p3_vld;
  logic signed [SUM_W:0]   p3_s;

  logic signed [T_W-1:0]   t_ext;
  logic signed [T_W-1:0]   t10;
  logic [Q_W-1:0]          q;
  logic [BIN_W-1:0]        bin_next;
  logic                    p4_vld;
  logic [BIN_W-1:0]        p4_bin;

  logic [CNT_W-1:0]        hist_mem [BINS_MAX];
  logic [BINS_MAX-1:0]     hv;
  logic [CNT_W-1:0]        hist_q;
  logic                    hist_vq;
  logic                    rd_en;
  logic [BIN_W-1:0]        rd_addr;

  logic                    p5_vld;
  logic [BIN_W-1:0]        p5_bin;
  logic                    hfwd;
  logic [CNT_W-1:0]        hfwd_cnt;
  logic [CNT_W-1:0]        cur;
  logic [CNT_W-1:0]        cnt_new;

  logic [BIN_W-1:0]        emit_i;
  logic                    adv;
  logic                    emit_re;
  logic                    emit_last;
  logic                    clear_all;
  logic                    drained;

  // average and offset by one
  always_comb begin
    shamt  = (4'(blk.bl) << 1) + 4'(blk.bl);
    avg    = $signed(blk.sum) >>> shamt;
    s_next = (SUM_W+1)'(avg) + (SUM_W+1)'(ONE_FIX);
  end

  // times ten, drop fraction, saturate
  always_comb begin
    t_ext    = T_W'(p3_s);
    t10      = (t_ext <<< 3) + (t_ext <<< 1);
    q        = t10[T_W-1:FRAC_W];
    if (p3_s[SUM_W]) begin
      bin_next = '0;
    end else if (q > Q_W'(nb_m1)) begin
      bin_next = nb_m1;
    end else begin
      bin_next = BIN_W'(q);
    end
  end

  always_comb begin
    rd_en   = p4_vld || emit_re;
    rd_addr = emit_re ? emit_i : p4_bin;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      hist_q  <= hist_mem[rd_addr];
      hist_vq <= hv[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (p5_vld) begin
      hist_mem[p5_bin] <= cnt_new;
    end
  end

  always_comb begin
    cur     = hfwd ? hfwd_cnt : (hist_vq ? hist_q : '0);
    cnt_new = (cur == COUNT_MAX) ? cur : cur + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= '0;
    end else if (clear_all) begin
      hv <= '0;
    end else if (p5_vld) begin
      hv[p5_bin] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
      p5_vld <= 1'b0;
      hfwd   <= 1'b0;
    end else begin
      p3_vld <= blk.vld;
      p4_vld <= p3_vld;
      p5_vld <= p4_vld;
      hfwd   <= p4_vld && p5_vld && (p4_bin == p5_bin);
    end
  end

  always_ff @(posedge clk) begin
    p3_s     <= s_next;
    p4_bin   <= bin_next;
    p5_bin   <= p4_bin;
    hfwd_cnt <= cnt_new;
  end

  // run sequencer
  always_comb begin
    drained   = !acc_busy && !p3_vld && !p4_vld && !p5_vld;
    adv       = !out_valid || !out_stall;
    emit_last = (emit_i == nb_m1);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_COUNT: begin
        if (run_start) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drained) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (adv && emit_last) state_next = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!out_stall) state_next = ST_COUNT;
      end
      default: state_next = ST_COUNT;
    endcase
  end

  always_comb begin
    busy      = (state != ST_COUNT);
    emit_re   = (state == ST_EMIT) && adv;
    clear_all = emit_re && emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COUNT;
      emit_i    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_re) begin
        emit_i    <= emit_last ? '0 : emit_i + 1'b1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_re) begin
      bin_index <= emit_i;
      last_bin  <= emit_last;
    end
  end

  assign block_count = hist_vq ? hist_q : '0;

  `BADH_ASSERT_IMP(a_emit_no_count, state == ST_EMIT, !p4_vld && !p5_vld)
  `BADH_ASSERT_IMP(a_out_only_in_run, out_valid, state == ST_EMIT || state == ST_FLUSH)
  `BADH_ASSERT_NXT(a_run_stalls_input, run_start, busy)
  `BADH_ASSERT_IMP(a_last_is_top_bin, out_valid && last_bin, bin_index == nb_m1)

endmodule
